@@ rtl/srx_pkg.sv @@
// SLIP receiver package: delimiter codes, word classes, status codes and the
// structs used by the front queue, the decode back end and the top level.
// No dependencies.
package srx_pkg;

    // SLIP special characters
    localparam logic [7:0] SLIP_FEND  = 8'hC0;
    localparam logic [7:0] SLIP_FESC  = 8'hDB;
    localparam logic [7:0] SLIP_TFEND = 8'hDC;
    localparam logic [7:0] SLIP_TFESC = 8'hDD;

    // Reset value of the raw byte limit
    localparam logic [15:0] RAW_LIMIT_RESET = 16'hFF;

    // Status codes reported with every result word
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_WAIT     = 3'd1;
    localparam logic [2:0] ST_RECV     = 3'd2;
    localparam logic [2:0] ST_COMPLETE = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    // Class of a raw line byte, worked out on entry to the queue
    typedef enum logic [2:0] {
        KIND_OTHER,
        KIND_FEND,
        KIND_FESC,
        KIND_TFEND,
        KIND_TFESC
    } byte_kind_t;

    // One queued word: an arm command or a classified raw byte
    typedef struct packed {
        logic       arm;
        byte_kind_t kind;
        logic [7:0] data;
    } srx_item_t;

    // One result word
    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_out;
        logic        frame_end;
        logic [2:0]  status;
        logic        escape_error;
        logic [15:0] payload_length;
    } srx_result_t;

    // Map a raw byte to its class
    function automatic byte_kind_t classify_byte(input logic [7:0] b);
        byte_kind_t k;
        case (b)
            SLIP_FEND:  k = KIND_FEND;
            SLIP_FESC:  k = KIND_FESC;
            SLIP_TFEND: k = KIND_TFEND;
            SLIP_TFESC: k = KIND_TFESC;
            default:    k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/slip_frame_receiver.sv @@
// SLIP frame receiver top level: raw byte limit register, front queue and
// decode back end. Uses srx_pkg, srx_front and srx_back.
//
// Takes one input word per clock while s_axis_tready is high (an arm command
// or a raw line byte) and returns exactly one result word for each, one per
// clock when the output side keeps m_axis_tready high; a result word passes
// through the queue and then the output register, where it is held until
// taken. The input queue holds QUEUE_DEPTH words; s_axis_tready drops while
// it is full. Decoded bytes are not buffered: a consumer drops a frame whose
// closing word (tlast) shows escape_error.
// Write cfg_wdata (raw byte limit, opening delimiter included) only while no
// word is in flight.
module slip_frame_receiver #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: raw byte limit
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] req_type
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_out, [10:8] status,
                                        // [11] escape_error,
                                        // [27:12] payload_length, [31:28] zero
    output logic        m_axis_tuser,   // [0] data_valid
    output logic        m_axis_tlast    // frame_end
);
    import srx_pkg::*;

    logic [15:0]  raw_limit_reg;
    logic         head_valid;
    srx_item_t    head;
    logic         pop;
    srx_result_t  out_word;

    // Hold the raw byte limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_limit_reg <= RAW_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            raw_limit_reg <= cfg_wdata;
        end
    end

    srx_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_arm     (s_axis_tuser),
        .in_byte    (s_axis_tdata),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    srx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_limit  (raw_limit_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (out_word)
    );

    // Pack the result word
    assign m_axis_tdata = {4'd0, out_word.payload_length, out_word.escape_error,
                           out_word.status, out_word.data_out};
    assign m_axis_tuser = out_word.data_valid;
    assign m_axis_tlast = out_word.frame_end;

endmodule

@@ rtl/srx_front.sv @@
// SLIP receiver front end: accepts input words, classifies each byte and
// holds the words in a short queue for the decode back end. Uses srx_pkg.
module srx_front #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_arm,
    input  logic [7:0]        in_byte,
    output logic              head_valid,
    output srx_pkg::srx_item_t head,
    input  logic              pop
);
    import srx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    srx_item_t            queue_mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 push;
    srx_item_t            push_item;

    assign in_ready   = (count_reg != FULL_CNT);
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != '0);
    assign head       = queue_mem[rd_ptr_reg];

    // Classify the byte as it enters
    always_comb
    begin
        push_item.arm  = in_arm;
        push_item.kind = classify_byte(in_byte);
        push_item.data = in_byte;
    end

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/srx_back.sv @@
// SLIP receiver back end: frame state machine, escape decoding, counters and
// the output register. Takes classified words from srx_front. Uses srx_pkg.
module srx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        raw_limit,
    input  logic               head_valid,
    input  srx_pkg::srx_item_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output srx_pkg::srx_result_t out_word
);
    import srx_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WAIT,
        MODE_RECV,
        MODE_OVERFLOW
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic         esc_pend_reg, esc_pend_next;
    logic         bad_esc_reg, bad_esc_next;
    logic [15:0]  raw_cnt_reg, raw_cnt_next;
    logic [15:0]  dec_cnt_reg, dec_cnt_next;
    logic         out_valid_reg;
    srx_result_t  out_word_reg;
    srx_result_t  res;

    // Take a word when the output register is free or being drained
    assign pop       = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Decode one word
    always_comb
    begin
        mode_next     = mode_reg;
        esc_pend_next = esc_pend_reg;
        bad_esc_next  = bad_esc_reg;
        raw_cnt_next  = raw_cnt_reg;
        dec_cnt_next  = dec_cnt_reg;
        res           = '0;
        res.status    = ST_IDLE;

        if (head.arm)
        begin
            mode_next     = MODE_WAIT;
            esc_pend_next = 1'b0;
            bad_esc_next  = 1'b0;
            raw_cnt_next  = '0;
            dec_cnt_next  = '0;
            res.status    = ST_WAIT;
        end
        else
        begin
            case (mode_reg)
                MODE_WAIT:
                begin
                    if (head.kind == KIND_FEND)
                    begin
                        mode_next     = MODE_RECV;
                        esc_pend_next = 1'b0;
                        bad_esc_next  = 1'b0;
                        raw_cnt_next  = 16'd1;
                        dec_cnt_next  = '0;
                        res.status    = ST_RECV;
                    end
                    else
                    begin
                        res.status = ST_WAIT;
                    end
                end
                MODE_RECV:
                begin
                    if (raw_cnt_reg >= raw_limit)
                    begin
                        // Drop the byte and hold overflow until re-armed
                        mode_next  = MODE_OVERFLOW;
                        res.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        raw_cnt_next = raw_cnt_reg + 16'd1;
                        if (head.kind == KIND_FEND)
                        begin
                            // Close the frame
                            res.frame_end    = 1'b1;
                            res.escape_error = bad_esc_reg || esc_pend_reg;
                            esc_pend_next    = 1'b0;
                            mode_next        = MODE_IDLE;
                            res.status       = ST_COMPLETE;
                        end
                        else
                        begin
                            if (bad_esc_reg)
                            begin
                                // Rest of the frame is suppressed
                            end
                            else if (esc_pend_reg)
                            begin
                                esc_pend_next = 1'b0;
                                if (head.kind == KIND_TFEND)
                                begin
                                    res.data_valid = 1'b1;
                                    res.data_out   = SLIP_FEND;
                                end
                                else if (head.kind == KIND_TFESC)
                                begin
                                    res.data_valid = 1'b1;
                                    res.data_out   = SLIP_FESC;
                                end
                                else
                                begin
                                    bad_esc_next = 1'b1;
                                end
                            end
                            else if (head.kind == KIND_FESC)
                            begin
                                esc_pend_next = 1'b1;
                            end
                            else
                            begin
                                res.data_valid = 1'b1;
                                res.data_out   = head.data;
                            end
                            if (res.data_valid)
                            begin
                                dec_cnt_next = dec_cnt_reg + 16'd1;
                            end
                            res.status = ST_RECV;
                        end
                    end
                end
                MODE_OVERFLOW:
                begin
                    res.status = ST_OVERFLOW;
                end
                default:
                begin
                    res.status = ST_IDLE;
                end
            endcase
        end
        res.payload_length = dec_cnt_next;
    end

    // Hold frame state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            esc_pend_reg  <= 1'b0;
            bad_esc_reg   <= 1'b0;
            raw_cnt_reg   <= '0;
            dec_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg      <= mode_next;
                esc_pend_reg  <= esc_pend_next;
                bad_esc_reg   <= bad_esc_next;
                raw_cnt_reg   <= raw_cnt_next;
                dec_cnt_reg   <= dec_cnt_next;
                out_valid_reg <= 1'b1;
                out_word_reg  <= res;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/srx_checker.sv @@
// Port-level checks for slip_frame_receiver, attached by the bind below.
// Uses srx_pkg.
module srx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    import srx_pkg::*;

    // Stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // Decoded data only while receiving
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[10:8] == ST_RECV)
        else $error("data word outside receiving status");

    // Frame end reports completion
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[10:8] == ST_COMPLETE && !m_axis_tuser)
        else $error("frame end without complete status");

    // Escape error only on the closing word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tlast)
        else $error("escape error outside frame end");

    // Data byte is zero when no decoded byte is carried
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("stray data byte");

endmodule

bind slip_frame_receiver srx_checker u_srx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
